[hw/rtl/uads_pkg.sv]
// Shared types and constants for the upwind advection-diffusion stencil.
// Grid geometry, fixed-point widths, register indexes and the saturation helper.
// No dependencies.
package uads_pkg;

    localparam int GRID_SIZE  = 128;
    localparam int CNT_W      = $clog2(GRID_SIZE);
    localparam int MEM_DEPTH  = 2 * GRID_SIZE;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int DATA_W     = 32;
    localparam int POS_W      = 7;
    localparam int NUM_FIELDS = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int SUM_W      = 53;

    localparam logic [15:0] ADVECT_RST   = 16'd4194;
    localparam logic [15:0] DIFFUSE_RST  = 16'd5369;
    localparam logic [16:0] PRESSURE_RST = 17'd26214;

    // Field lanes inside one memory word and in the window registers.
    localparam int F_VX  = 0;
    localparam int F_VY  = 1;
    localparam int F_RHO = 2;
    localparam int F_TMP = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADVECT   = 2'd0,
        CFG_DIFFUSE  = 2'd1,
        CFG_PRESSURE = 2'd2
    } t_cfg_idx;

    typedef logic signed [DATA_W-1:0] t_q16;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_meta;

    function automatic t_q16 sat_q16(input logic signed [SUM_W-1:0] v);
        t_q16 res;
        if (v > SUM_W'(64'sh7FFF_FFFF)) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -SUM_W'(64'sh8000_0000)) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/upwind_advection_diffusion_stencil.sv]
// Top level of the upwind advection-diffusion stencil engine.
// Holds the line memory, the cross window and the arithmetic pipeline.
// Depends on uads_pkg.

// The block takes one grid cell per clock in raster order while the output is not
// stalled and, for every interior cell, returns its one-step update once the cell
// that completes its neighborhood has been accepted and has passed through the
// pipeline. The rate of one cell per clock is set by the line memory, which is
// read at two rows and written at one row in the same cycle; the rest is a
// seven-stage pipeline with a separate hold on every stage, so bubbles close up
// while the output is stalled. The line memory has no reset and no clearing pass:
// the first two rows of every grid fill it before any result depends on it.
module upwind_advection_diffusion_stencil (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [uads_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [uads_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [31:0]             i_vel_x,
    input  logic signed [31:0]             i_vel_y,
    input  logic signed [31:0]             i_density,
    input  logic signed [31:0]             i_temperature,
    input  logic                           i_frame_start,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [31:0]             o_vel_x_next,
    output logic signed [31:0]             o_vel_y_next,
    output logic signed [31:0]             o_pressure_next,
    output logic signed [31:0]             o_density_next,
    output logic signed [31:0]             o_temperature_next,
    output logic [6:0]                     o_out_row,
    output logic [6:0]                     o_out_col,
    output logic                           o_frame_last
);
    import uads_pkg::*;

    // Configuration registers.
    logic [15:0] r_advect;
    logic [15:0] r_diffuse;
    logic [16:0] r_pressure;

    // Position counters.
    logic [CNT_W-1:0] r_row_cnt, r_col_cnt;
    logic [CNT_W-1:0] n_row_cnt, n_col_cnt;
    logic [CNT_W-1:0] cur_row, cur_col;

    // Line memory: one word holds all four fields of a cell.
    logic [NUM_FIELDS-1:0][DATA_W-1:0] mem [MEM_DEPTH];
    logic [NUM_FIELDS-1:0][DATA_W-1:0] in_word;
    logic [MEM_AW-1:0] addr_cur, addr_prev;
    logic [NUM_FIELDS-1:0][DATA_W-1:0] r_rd_cur, r_rd_prev;

    // Stage valid bits and hold logic.
    logic [7:1] r_vld;
    logic [8:2] rdy;
    logic       accept, emit1, mv1;

    // Stage 1.
    t_q16 r1_x [NUM_FIELDS];
    logic [CNT_W-1:0] r1_row, r1_col;

    // Cross window: up, left, centre and down of each field.
    t_q16 r_w_up [NUM_FIELDS];
    t_q16 r_w_left [NUM_FIELDS];
    t_q16 r_w_ctr [NUM_FIELDS];
    t_q16 r_w_down [NUM_FIELDS];

    // Stage 2: differences and Laplacians.
    logic signed [32:0] r2_dl [NUM_FIELDS];
    logic signed [32:0] r2_du [NUM_FIELDS];
    t_q16               r2_ctr [NUM_FIELDS];
    logic signed [35:0] r2_lap [2];
    t_meta              r2_meta, n2_meta;

    // Stage 3: floored products.
    logic signed [48:0] r3_pl [NUM_FIELDS];
    logic signed [48:0] r3_pu [NUM_FIELDS];
    t_q16               r3_ctr [NUM_FIELDS];
    logic signed [36:0] r3_lapd [2];
    t_meta              r3_meta;

    // Stage 4: advection terms.
    logic signed [50:0] r4_adv [NUM_FIELDS];
    t_q16               r4_ctr [NUM_FIELDS];
    logic signed [36:0] r4_lapd [2];
    t_meta              r4_meta;

    // Stage 5: saturated field updates.
    t_q16  r5_val [NUM_FIELDS];
    t_meta r5_meta;

    // Stage 6: density times temperature.
    logic signed [47:0] r6_rt;
    t_q16               r6_val [NUM_FIELDS];
    t_meta              r6_meta;

    // Stage 7: output register.
    t_q16  r7_val [NUM_FIELDS];
    t_q16  r7_pres;
    t_meta r7_meta;

    // ------------------------------------------------------------------
    // Handshake and hold chain.
    // ------------------------------------------------------------------
    always_comb begin
        rdy[8] = i_out_ready;
        for (int k = 7; k >= 2; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    // A cell that yields no result leaves stage 1 without entering stage 2.
    assign emit1      = (r1_row >= CNT_W'(2)) && (r1_col >= CNT_W'(2));
    assign mv1        = r_vld[1] && (!emit1 || rdy[2]);
    assign o_in_ready = !r_vld[1] || !emit1 || rdy[2];
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (o_in_ready) begin
                r_vld[1] <= i_in_valid;
            end
            if (rdy[2]) begin
                r_vld[2] <= mv1 && emit1;
            end
            for (int k = 3; k <= 7; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_advect   <= ADVECT_RST;
            r_diffuse  <= DIFFUSE_RST;
            r_pressure <= PRESSURE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_ADVECT:   r_advect   <= i_cfg_wdata[15:0];
                CFG_DIFFUSE:  r_diffuse  <= i_cfg_wdata[15:0];
                CFG_PRESSURE: r_pressure <= i_cfg_wdata;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Counters and line memory.
    // ------------------------------------------------------------------
    always_comb begin
        cur_row = i_frame_start ? '0 : r_row_cnt;
        cur_col = i_frame_start ? '0 : r_col_cnt;
        n_row_cnt = cur_row;
        n_col_cnt = cur_col + 1'b1;
        if (cur_col == CNT_W'(GRID_SIZE - 1)) begin
            n_col_cnt = '0;
            n_row_cnt = (cur_row == CNT_W'(GRID_SIZE - 1)) ? '0 : cur_row + 1'b1;
        end
        addr_cur  = (cur_row[0] ? MEM_AW'(GRID_SIZE) : '0) + MEM_AW'(cur_col);
        addr_prev = (cur_row[0] ? '0 : MEM_AW'(GRID_SIZE)) + MEM_AW'(cur_col);
        in_word[F_VX]  = i_vel_x;
        in_word[F_VY]  = i_vel_y;
        in_word[F_RHO] = i_density;
        in_word[F_TMP] = i_temperature;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (accept) begin
            r_row_cnt <= n_row_cnt;
            r_col_cnt <= n_col_cnt;
        end
    end

    // The read at the written address returns the row two back, as intended.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_cur        <= mem[addr_cur];
            r_rd_prev       <= mem[addr_prev];
            mem[addr_cur]   <= in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_row <= cur_row;
            r1_col <= cur_col;
            for (int f = 0; f < NUM_FIELDS; f++) begin
                r1_x[f] <= in_word[f];
            end
        end
    end

    // ------------------------------------------------------------------
    // Cross window, advanced once per cell as it leaves stage 1.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mv1) begin
            for (int f = 0; f < NUM_FIELDS; f++) begin
                r_w_left[f] <= r_w_ctr[f];
                r_w_ctr[f]  <= r_rd_prev[f];
                r_w_up[f]   <= r_rd_cur[f];
                r_w_down[f] <= r1_x[f];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: differences and Laplacians of the old values.
    // ------------------------------------------------------------------
    always_comb begin
        n2_meta.row  = POS_W'(r1_row - 1'b1);
        n2_meta.col  = POS_W'(r1_col - 1'b1);
        n2_meta.last = (r1_row == CNT_W'(GRID_SIZE - 1)) &&
                       (r1_col == CNT_W'(GRID_SIZE - 1));
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_meta <= n2_meta;
            for (int f = 0; f < NUM_FIELDS; f++) begin
                r2_dl[f]  <= 33'(r_w_ctr[f]) - 33'(r_w_left[f]);
                r2_du[f]  <= 33'(r_w_ctr[f]) - 33'(r_w_up[f]);
                r2_ctr[f] <= r_w_ctr[f];
            end
            for (int f = 0; f < 2; f++) begin
                r2_lap[f] <= 36'(r_w_up[f]) + 36'(r_w_left[f]) + 36'($signed(r_rd_prev[f]))
                           + 36'(r_w_down[f]) - (36'(r_w_ctr[f]) <<< 2);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: velocity products and diffusion, floored to Q16.16.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        logic signed [64:0] pl, pu;
        logic signed [52:0] pd;
        if (rdy[3]) begin
            r3_meta <= r2_meta;
            for (int f = 0; f < NUM_FIELDS; f++) begin
                pl = 65'(r2_ctr[F_VX] * r2_dl[f]);
                pu = 65'(r2_ctr[F_VY] * r2_du[f]);
                r3_pl[f]  <= pl[64:16];
                r3_pu[f]  <= pu[64:16];
                r3_ctr[f] <= r2_ctr[f];
            end
            for (int f = 0; f < 2; f++) begin
                pd = 53'(r2_lap[f] * $signed({1'b0, r_diffuse}));
                r3_lapd[f] <= pd[52:16];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: advection term scaled by the advection coefficient.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        logic signed [49:0] s;
        logic signed [66:0] pa;
        if (rdy[4]) begin
            r4_meta <= r3_meta;
            r4_lapd <= r3_lapd;
            for (int f = 0; f < NUM_FIELDS; f++) begin
                s  = 50'(r3_pl[f] + r3_pu[f]);
                pa = 67'(s * $signed({1'b0, r_advect}));
                r4_adv[f] <= pa[66:16];
                r4_ctr[f] <= r3_ctr[f];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: combine and saturate.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        logic signed [SUM_W-1:0] v;
        if (rdy[5]) begin
            r5_meta <= r4_meta;
            for (int f = 0; f < NUM_FIELDS; f++) begin
                v = SUM_W'(r4_ctr[f]) - SUM_W'(r4_adv[f]);
                if (f < 2) begin
                    v = v + SUM_W'(r4_lapd[f]);
                end
                r5_val[f] <= sat_q16(v);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 6 and 7: pressure from the saturated density and temperature.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        logic signed [63:0] prt;
        prt = 64'(r5_val[F_RHO] * r5_val[F_TMP]);
        if (rdy[6]) begin
            r6_meta <= r5_meta;
            r6_val  <= r5_val;
            r6_rt   <= prt[63:16];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [65:0] pp;
        pp = 66'(r6_rt * $signed({1'b0, r_pressure}));
        if (rdy[7]) begin
            r7_meta <= r6_meta;
            r7_val  <= r6_val;
            r7_pres <= sat_q16(SUM_W'($signed(pp[65:16])));
        end
    end

    assign o_out_valid        = r_vld[7];
    assign o_vel_x_next       = r7_val[F_VX];
    assign o_vel_y_next       = r7_val[F_VY];
    assign o_density_next     = r7_val[F_RHO];
    assign o_temperature_next = r7_val[F_TMP];
    assign o_pressure_next    = r7_pres;
    assign o_out_row          = r7_meta.row;
    assign o_out_col          = r7_meta.col;
    assign o_frame_last       = r7_meta.last;

`ifndef ASSERT_OFF
    // A waiting output transaction stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_row) && $stable(o_out_col))
        else $error("output transaction changed while stalled");

    // A frame start places the accepted cell at the grid origin.
    a_frame_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_frame_start |=> (r1_row == '0) && (r1_col == '0))
        else $error("frame start did not restart the position");

    // The last result of a grid is the bottom-right interior cell.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_last |->
            (o_out_row == POS_W'(GRID_SIZE - 2)) && (o_out_col == POS_W'(GRID_SIZE - 2)))
        else $error("frame_last on a cell other than the final interior cell");

    // Stage 1 never holds a cell that yields no result: such a cell always has a free path.
    a_no_stuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && !emit1 |-> mv1 && o_in_ready)
        else $error("border cell held in stage one");
`endif

endmodule

[tb/upwind_advection_diffusion_stencil_test.sv]
// Self-checking testbench for the upwind advection-diffusion stencil.
// Streams grid cells through valid/ready, predicts every interior update in place
// and checks each output transaction. Depends on uads_pkg and the stencil RTL.
`timescale 1ns / 100ps

module upwind_advection_diffusion_stencil_test;
    import uads_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_q16             vx;
        t_q16             vy;
        t_q16             pres;
        t_q16             rho;
        t_q16             tmp;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_cell_update;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam t_wide Q_MAX = 2147483647;
    localparam t_wide Q_MIN = -Q_MAX - 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 20;

    // Value styles for generated cells.
    localparam int VAL_FULL = 0;
    localparam int VAL_SMALL = 1;
    localparam int VAL_EXTREME = 2;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic signed [31:0]    i_vel_x;
    logic signed [31:0]    i_vel_y;
    logic signed [31:0]    i_density;
    logic signed [31:0]    i_temperature;
    logic                  i_frame_start;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [31:0]    o_vel_x_next;
    logic signed [31:0]    o_vel_y_next;
    logic signed [31:0]    o_pressure_next;
    logic signed [31:0]    o_density_next;
    logic signed [31:0]    o_temperature_next;
    logic [6:0]            o_out_row;
    logic [6:0]            o_out_col;
    logic                  o_frame_last;

    upwind_advection_diffusion_stencil dut (.*);

    // Predictor state: line stores, cross window, position and coefficients.
    longint line_store[NUM_FIELDS][2*GRID_SIZE];
    longint win_up[NUM_FIELDS];
    longint win_left[NUM_FIELDS];
    longint win_centre[NUM_FIELDS];
    longint win_down[NUM_FIELDS];
    int     cell_row;
    int     cell_col;
    longint advect_k;
    longint diffuse_k;
    longint pressure_k;

    t_cell_update pending_updates[$];
    int errors = 0;
    int cycles = 0;
    int burst_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("upwind_advection_diffusion_stencil_test: done, errors");
            $finish;
        end
    end

    function automatic t_wide floor16(input t_wide v);
        return v >>> 16;
    endfunction

    function automatic t_wide clamp_q16(input t_wide v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    function automatic t_wide upwind(input longint up, input longint left,
                                     input longint centre, input longint u,
                                     input longint v);
        t_wide s;
        s = floor16(t_wide'(u) * (t_wide'(centre) - t_wide'(left)))
            + floor16(t_wide'(v) * (t_wide'(centre) - t_wide'(up)));
        return t_wide'(centre) - floor16(s * t_wide'(advect_k));
    endfunction

    // Advances the predictor by one cell; returns 1 when an interior update results.
    function automatic bit compute_cell_update(input longint vals[NUM_FIELDS],
                                               input bit fs,
                                               output t_cell_update upd);
        longint up[NUM_FIELDS], left[NUM_FIELDS], ctr[NUM_FIELDS];
        longint right[NUM_FIELDS], down[NUM_FIELDS];
        int r, c, cur, prev;
        t_wide lap, ux, vy, rn, tn, pn;
        if (fs) begin
            cell_row = 0;
            cell_col = 0;
        end
        r = cell_row;
        c = cell_col;
        cur = (r % 2) * GRID_SIZE + c;
        prev = ((r + 1) % 2) * GRID_SIZE + c;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            up[f] = win_up[f];
            left[f] = win_left[f];
            ctr[f] = win_centre[f];
            right[f] = line_store[f][prev];
            down[f] = win_down[f];
            win_left[f] = win_centre[f];
            win_centre[f] = right[f];
            win_up[f] = line_store[f][cur];
            win_down[f] = vals[f];
            line_store[f][cur] = vals[f];
        end
        cell_col = c + 1;
        if (cell_col >= GRID_SIZE) begin
            cell_col = 0;
            cell_row = (r + 1 >= GRID_SIZE) ? 0 : r + 1;
        end
        if (r < 2 || c < 2) return 0;
        lap = t_wide'(up[F_VX]) + left[F_VX] + right[F_VX] + down[F_VX] - 4 * t_wide'(ctr[F_VX]);
        ux = clamp_q16(upwind(up[F_VX], left[F_VX], ctr[F_VX], ctr[F_VX], ctr[F_VY])
                       + floor16(lap * t_wide'(diffuse_k)));
        lap = t_wide'(up[F_VY]) + left[F_VY] + right[F_VY] + down[F_VY] - 4 * t_wide'(ctr[F_VY]);
        vy = clamp_q16(upwind(up[F_VY], left[F_VY], ctr[F_VY], ctr[F_VX], ctr[F_VY])
                       + floor16(lap * t_wide'(diffuse_k)));
        rn = clamp_q16(upwind(up[F_RHO], left[F_RHO], ctr[F_RHO], ctr[F_VX], ctr[F_VY]));
        tn = clamp_q16(upwind(up[F_TMP], left[F_TMP], ctr[F_TMP], ctr[F_VX], ctr[F_VY]));
        pn = clamp_q16(floor16(floor16(rn * tn) * t_wide'(pressure_k)));
        upd.vx = ux[31:0];
        upd.vy = vy[31:0];
        upd.rho = rn[31:0];
        upd.tmp = tn[31:0];
        upd.pres = pn[31:0];
        upd.row = POS_W'(r - 1);
        upd.col = POS_W'(c - 1);
        upd.last = (r == GRID_SIZE - 1) && (c == GRID_SIZE - 1);
        return 1;
    endfunction

    function automatic longint cell_value(input int style);
        longint picks[7] = '{2147483647, -2147483647 - 1, 0, 1, -1, 65536, -65536};
        case (style)
            VAL_SMALL:   return longint'($urandom_range(0, 32'h000F_FFFF))
                                - longint'(32'h0008_0000);
            VAL_EXTREME: return picks[$urandom_range(0, 6)];
            default:     return longint'($signed($urandom()));
        endcase
    endfunction

    // Presents one cell and waits for its transaction; the sender may idle between bursts.
    task automatic send_cell(input int style, input bit fs);
        longint vals[NUM_FIELDS];
        t_cell_update upd;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        for (int f = 0; f < NUM_FIELDS; f++) vals[f] = cell_value(style);
        i_vel_x <= vals[F_VX][31:0];
        i_vel_y <= vals[F_VY][31:0];
        i_density <= vals[F_RHO][31:0];
        i_temperature <= vals[F_TMP][31:0];
        i_frame_start <= fs;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (compute_cell_update(vals, fs, upd))
            pending_updates.insert(pending_updates.size(), upd);
    endtask

    task automatic send_frame(input int ncells, input int style);
        for (int i = 0; i < ncells; i++) send_cell(style, i == 0);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ADVECT:   advect_k = val[15:0];
            CFG_DIFFUSE:  diffuse_k = val[15:0];
            CFG_PRESSURE: pressure_k = val;
            default: ;
        endcase
    endtask

    task automatic set_coeffs(input logic [16:0] a, input logic [16:0] d, input logic [16:0] p);
        write_reg(CFG_ADVECT, a);
        write_reg(CFG_DIFFUSE, d);
        write_reg(CFG_PRESSURE, p);
    endtask

    // Reset coefficients with saturating corner values in the window.
    task automatic test_extremes();
        send_frame(2 * GRID_SIZE + 20, VAL_EXTREME);
        wait_idle();
    endtask

    // Zero and full-scale coefficients, then a return to the reset values; bits above a
    // register's width and the unused index must have no effect.
    task automatic test_coefficients();
        set_coeffs(17'd0, 17'd0, 17'd0);
        send_frame(2 * GRID_SIZE + 6, VAL_FULL);
        wait_idle();
        set_coeffs(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        write_reg(CFG_UNUSED, 17'h0);
        send_frame(2 * GRID_SIZE + 6, VAL_EXTREME);
        wait_idle();
        set_coeffs(17'(ADVECT_RST), 17'(DIFFUSE_RST), PRESSURE_RST);
    endtask

    // A new frame starts partway through a row; older rows must not leak in.
    task automatic test_frame_restart();
        send_frame(2 * GRID_SIZE + 40, VAL_SMALL);
        send_frame(2 * GRID_SIZE + 6, VAL_FULL);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int sent;
        sent = 0;
        while (sent < 2 * GRID_SIZE) begin
            int n;
            n = $urandom_range(2 * GRID_SIZE + 60, 2 * GRID_SIZE + 160);
            if ($urandom_range(0, 4) == 0) begin
                wait_idle();
                set_coeffs(17'($urandom_range(0, 65535)), 17'($urandom_range(0, 65535)),
                           17'($urandom_range(0, 131071)));
            end
            send_frame(n, ($urandom_range(0, 3) == 0) ? VAL_FULL : VAL_SMALL);
            sent += n;
            if ($urandom_range(0, 2) == 0) wait_idle();
        end
        wait_idle();
    endtask

    // Receiver stalls: runs of steady ready, random ready and long holds.
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(10, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= $urandom_range(0, 1);
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic note_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_cell_update want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_updates.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction at row %0d col %0d", o_out_row, o_out_col);
            end else begin
                want = pending_updates.pop_front();
                if (o_vel_x_next !== want.vx) note_mismatch("vel_x", want.vx, o_vel_x_next);
                if (o_vel_y_next !== want.vy) note_mismatch("vel_y", want.vy, o_vel_y_next);
                if (o_pressure_next !== want.pres)
                    note_mismatch("pressure", want.pres, o_pressure_next);
                if (o_density_next !== want.rho)
                    note_mismatch("density", want.rho, o_density_next);
                if (o_temperature_next !== want.tmp)
                    note_mismatch("temperature", want.tmp, o_temperature_next);
                if (o_out_row !== want.row) note_mismatch("row", want.row, o_out_row);
                if (o_out_col !== want.col) note_mismatch("col", want.col, o_out_col);
                if (o_frame_last !== want.last) note_mismatch("last", want.last, o_frame_last);
            end
        end
    end

    initial begin
        burst_left = 0;
        cell_row = 0;
        cell_col = 0;
        advect_k = ADVECT_RST;
        diffuse_k = DIFFUSE_RST;
        pressure_k = PRESSURE_RST;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            win_up[f] = 0;
            win_left[f] = 0;
            win_centre[f] = 0;
            win_down[f] = 0;
            for (int a = 0; a < 2 * GRID_SIZE; a++) line_store[f][a] = 0;
        end
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_addr <= CFG_ADVECT;
        i_cfg_wdata <= '0;
        i_in_valid <= 1'b0;
        i_vel_x <= '0;
        i_vel_y <= '0;
        i_density <= '0;
        i_temperature <= '0;
        i_frame_start <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_coefficients();
        test_frame_restart();
        test_random_frames();
        if (errors == 0 && pending_updates.size() == 0) begin
            $display("upwind_advection_diffusion_stencil_test: done, clean");
        end else begin
            $display("upwind_advection_diffusion_stencil_test: done, errors");
        end
        $finish;
    end

endmodule
